>>> src/timed_event_table_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Timed event table sequencer - assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_TABLE_SEQUENCER_MACROS_SVH
`define TIMED_EVENT_TABLE_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TETS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TETS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tets_pkg.sv
// ----------------------------------------------------------------------------
// tets_pkg
// Types, codes and constants of the timed event table sequencer.
// ----------------------------------------------------------------------------
package tets_pkg;

   // table size default and burst limit per tick
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int BURST_MAX       = 16;
   localparam int BURST_W         = $clog2(BURST_MAX + 1);

   // request kinds
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_START = 3'd1;
   localparam logic [2:0] REQ_STOP  = 3'd2;
   localparam logic [2:0] REQ_RESET = 3'd3;
   localparam logic [2:0] REQ_LOAD  = 3'd4;

   // event kinds
   localparam logic [3:0] KIND_NOP      = 4'd0;
   localparam logic [3:0] KIND_END      = 4'd1;
   localparam logic [3:0] KIND_LCL      = 4'd2;
   localparam logic [3:0] KIND_GPIO_SET = 4'd3;
   localparam logic [3:0] KIND_GPIO_CLR = 4'd4;
   localparam logic [3:0] KIND_CAL      = 4'd5;
   localparam logic [3:0] KIND_ACT_A    = 4'd6;
   localparam logic [3:0] KIND_ACT_B    = 4'd7;
   localparam logic [3:0] KIND_ACT_C    = 4'd8;

   // outcome codes
   localparam logic [1:0] OUT_EXECUTED  = 2'd0;
   localparam logic [1:0] OUT_SKIPPED   = 2'd1;
   localparam logic [1:0] OUT_RANGE     = 2'd2;
   localparam logic [1:0] OUT_NO_ACTION = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_POWER_SWITCHES = 2'd0;
   localparam logic [1:0] CSR_GPIO_PINS      = 2'd1;
   localparam logic [1:0] CSR_CALIBRATIONS   = 2'd2;

   // configuration reset values
   localparam logic [7:0] POWER_SWITCHES_RST = 8'd8;
   localparam logic [7:0] GPIO_PINS_RST      = 8'd32;
   localparam logic [7:0] CALIBRATIONS_RST   = 8'd4;

   // one table entry
   typedef struct packed {
      logic [31:0] ev_time;
      logic [3:0]  kind;
      logic [31:0] argument;
      logic [7:0]  flags;
   } tets_entry_type;

   // table read result: entry plus its written mark
   typedef struct packed {
      logic           written;
      tets_entry_type entry;
   } tets_read_type;

endpackage

>>> src/tets_table.sv
// ----------------------------------------------------------------------------
// tets_table
// Event table: one write port, one registered read port. Per-entry written
// bits make unwritten entries read as END right after reset.
// ----------------------------------------------------------------------------
module tets_table import tets_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int AW          = $clog2(TABLE_DEPTH),
   parameter int SW          = $clog2(TABLE_DEPTH + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  tets_entry_type wr_data,
   input  logic           rd_en,
   input  logic [SW-1:0]  rd_addr,
   output tets_read_type  rd_data
);

   tets_entry_type         mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] written_ff;
   tets_read_type          rd_ff;
   logic                   rd_in_range;

   assign rd_in_range = (rd_addr < SW'(TABLE_DEPTH));

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // written marks, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read; out-of-range addresses read as not written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_in_range) begin
            rd_ff.entry   <= mem_ff[rd_addr[AW-1:0]];
            rd_ff.written <= written_ff[rd_addr[AW-1:0]];
         end else begin
            rd_ff.written <= 1'b0;
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

>>> src/timed_event_table_sequencer.sv
// ----------------------------------------------------------------------------
// timed_event_table_sequencer
// Stopwatch clock beside a time-sorted event table. Each running tick walks the
// table from the next slot and reports each due entry, up to BURST_MAX per tick, with an outcome.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  req     | in        | req_tvalid/tready    | tuser: req_type; tdata: fields
//  rsp     | out       | rsp_tvalid/tready    | tdata: event fields; tlast: last
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
//  Stop, reset clock, load, unknown codes and a tick while stopped are
//  handled in the idle state; start makes two passes through the one
//  shared 32-bit subtractor. A running tick computes the elapsed time, then
//  for each consumed entry does a registered table read and a time compare
//  on the same subtractor; one more read and compare pair finds the end of
//  the walk. Each result is held back one entry so its last flag is known;
//  a stalled rsp side holds the walk in place.
//  Reset is synchronous; the table reads END at once, with no clearing pass.
//
`include "timed_event_table_sequencer_macros.svh"

module timed_event_table_sequencer import tets_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // [2:0] req_type
   // [31:0] now_ms, [32] booted_after_liftoff, [36:33] entry_index,
   // [68:37] entry_time, [72:69] entry_type, [104:73] entry_param,
   // [112:105] entry_flags, [119:113] zero
   input  logic [119:0] req_tdata,
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] event_kind, [35:4] event_argument, [39:36] slot, [41:40] outcome,
   // [47:42] zero
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tlast,
   // configuration writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (SW > 4) ? SW : 4;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EVAL  = 2'd3;

   // result record held ahead of the output register
   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] argument;
      logic [3:0]  slot;
      logic [1:0]  outcome;
   } result_type;

   // input fields
   logic [2:0]     req_kind;
   logic [31:0]    req_now_ms;
   logic           req_booted;
   logic [3:0]     req_entry_index;
   tets_entry_type req_entry;
   logic           req_fire;

   assign req_kind           = req_tuser;
   assign req_now_ms         = req_tdata[31:0];
   assign req_booted         = req_tdata[32];
   assign req_entry_index    = req_tdata[36:33];
   assign req_entry.ev_time  = req_tdata[68:37];
   assign req_entry.kind     = req_tdata[72:69];
   assign req_entry.argument = req_tdata[104:73];
   assign req_entry.flags    = req_tdata[112:105];

   // registers
   logic [1:0]         state_ff, state_in;
   logic [31:0]        start_mark_ff, start_mark_in;
   logic [31:0]        stop_mark_ff, stop_mark_in;
   logic               running_ff, running_in;
   logic [SW-1:0]      next_slot_ff, next_slot_in;
   logic [BURST_W-1:0] count_ff, count_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic [31:0]        now_ff, now_in;
   logic               booted_ff, booted_in;
   logic               pend_v_ff, pend_v_in;
   result_type         pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [7:0]         power_switches_ff;
   logic [7:0]         gpio_pins_ff;
   logic [7:0]         calibrations_ff;

   // table port
   logic          tbl_wr_en;
   logic          tbl_rd_en;
   tets_read_type tbl_rd;

   // shared subtractor
   logic [31:0] sub_a;
   logic [31:0] sub_b;
   logic [32:0] sub_res;

   logic       rsp_free;
   logic       walk_ok;
   logic       due;
   result_type cand;

   // outcome of one consumed entry
   function automatic logic [1:0] judge(input tets_entry_type e, input logic booted,
                                        input logic [7:0] psw, input logic [7:0] gpio,
                                        input logic [7:0] cal);
      logic [7:0] bound;
      logic       bounded;
      bound   = 8'd0;
      bounded = 1'b0;
      if (e.flags[0] && booted) begin
         return OUT_SKIPPED;
      end
      case (e.kind)
         KIND_LCL: begin
            bound   = psw;
            bounded = 1'b1;
         end
         KIND_GPIO_SET, KIND_GPIO_CLR: begin
            bound   = gpio;
            bounded = 1'b1;
         end
         KIND_CAL: begin
            bound   = cal;
            bounded = 1'b1;
         end
         KIND_ACT_A, KIND_ACT_B, KIND_ACT_C: begin
            return OUT_EXECUTED;
         end
         default: begin
            return OUT_NO_ACTION;
         end
      endcase
      if (bounded && (e.argument < {24'd0, bound})) begin
         return OUT_EXECUTED;
      end
      return OUT_RANGE;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // operand select for the shared subtractor
   always_comb begin
      sub_a = elapsed_ff;
      sub_b = tbl_rd.entry.ev_time;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_kind == REQ_START) begin
               sub_a = stop_mark_ff;
            end else begin
               sub_a = req_now_ms;
            end
            sub_b = start_mark_ff;
         end
         ST_START: begin
            sub_a = now_ff;
            sub_b = elapsed_ff;
         end
         ST_READ: begin
            sub_a = elapsed_ff;
            sub_b = start_mark_ff;
         end
         ST_EVAL: begin
            sub_a = elapsed_ff;
            sub_b = tbl_rd.entry.ev_time;
         end
         default: begin
            sub_a = elapsed_ff;
         end
      endcase
   end

   assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};

   // due test on the entry just read; borrow means its time is later
   assign walk_ok = (next_slot_ff < SW'(TABLE_DEPTH)) && (count_ff < BURST_W'(BURST_MAX));
   assign due     = walk_ok && tbl_rd.written && (tbl_rd.entry.kind != KIND_END)
                    && !sub_res[32];

   assign cand.kind     = tbl_rd.entry.kind;
   assign cand.argument = tbl_rd.entry.argument;
   assign cand.slot     = 4'(next_slot_ff);
   assign cand.outcome  = judge(tbl_rd.entry, booted_ff, power_switches_ff, gpio_pins_ff,
                                calibrations_ff);

   // table write on a load inside the table range
   assign tbl_wr_en = req_fire && (req_kind == REQ_LOAD)
                      && (CW'(req_entry_index) < CW'(TABLE_DEPTH));
   assign tbl_rd_en = (state_ff == ST_READ);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      start_mark_in = start_mark_ff;
      stop_mark_in  = stop_mark_ff;
      running_in    = running_ff;
      next_slot_in  = next_slot_ff;
      count_in      = count_ff;
      elapsed_in    = elapsed_ff;
      now_in        = now_ff;
      booted_in     = booted_ff;
      pend_v_in     = pend_v_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  REQ_TICK: begin
                     if (running_ff) begin
                        elapsed_in = sub_res[31:0];
                        booted_in  = req_booted;
                        count_in   = '0;
                        state_in   = ST_READ;
                     end
                  end
                  REQ_START: begin
                     if (!running_ff) begin
                        elapsed_in = sub_res[31:0];
                        now_in     = req_now_ms;
                        state_in   = ST_START;
                     end
                  end
                  REQ_STOP: begin
                     if (running_ff) begin
                        stop_mark_in = req_now_ms;
                        running_in   = 1'b0;
                     end
                  end
                  REQ_RESET: begin
                     start_mark_in = running_ff ? req_now_ms : 32'd0;
                     stop_mark_in  = 32'd0;
                     next_slot_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_START: begin
            start_mark_in = sub_res[31:0];
            stop_mark_in  = 32'd0;
            running_in    = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // hold while the held-back result cannot move out
            if (!pend_v_ff || rsp_free) begin
               if (pend_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
                  rsp_last_in  = !due;
               end
               if (due) begin
                  pend_v_in    = 1'b1;
                  pend_in      = cand;
                  next_slot_in = next_slot_ff + SW'(1);
                  count_in     = count_ff + BURST_W'(1);
                  state_in     = ST_READ;
               end else begin
                  pend_v_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_mark_ff <= 32'd0;
         stop_mark_ff  <= 32'd0;
         running_ff    <= 1'b0;
         next_slot_ff  <= '0;
         count_ff      <= '0;
         pend_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_mark_ff <= start_mark_in;
         stop_mark_ff  <= stop_mark_in;
         running_ff    <= running_in;
         next_slot_ff  <= next_slot_in;
         count_ff      <= count_in;
         pend_v_ff     <= pend_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      elapsed_ff  <= elapsed_in;
      now_ff      <= now_in;
      booted_ff   <= booted_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_switches_ff <= POWER_SWITCHES_RST;
         gpio_pins_ff      <= GPIO_PINS_RST;
         calibrations_ff   <= CALIBRATIONS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POWER_SWITCHES: power_switches_ff <= csr_wdata;
            CSR_GPIO_PINS:      gpio_pins_ff      <= csr_wdata;
            CSR_CALIBRATIONS:   calibrations_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // event table
   tets_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .SW          (SW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_entry),
      .rd_en   (tbl_rd_en),
      .rd_addr (next_slot_ff),
      .rd_data (tbl_rd)
   );

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.outcome, rsp_ff.slot, rsp_ff.argument, rsp_ff.kind};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `TETS_ASSERT_NOW(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_v_ff, "pending result left at idle")
   `TETS_ASSERT_NOW(a_slot_bound, clock, reset, 1'b1, next_slot_ff <= SW'(TABLE_DEPTH), "next slot past table end")
   `TETS_ASSERT_NEXT(a_stopped_tick, clock, reset, req_fire && req_kind == REQ_TICK && !running_ff, state_ff == ST_IDLE, "tick while stopped started a walk")

endmodule

>>> tb/timed_event_table_sequencer_test.sv
// ----------------------------------------------------------------------------
// timed_event_table_sequencer_test
// Drives clock requests, table loads and ticks into the sequencer through
// its stream ports and checks every dispatched event against an in-bench
// model of the stopwatch and table walk. A directed pass covers the outcome
// rules and clock wrap-around. Random schedules then run under several
// limit settings, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module timed_event_table_sequencer_test;
   import tets_pkg::*;

   localparam int DEPTH          = TABLE_DEPTH_DEF;
   localparam int SETTLE_CYCLES  = 48;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASES         = 5;
   localparam int PHASE_ITEMS    = 40;

   // request codes the block ignores
   localparam logic [2:0] REQ_SPARE_5 = 3'd5;
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;

   // highest unknown event kind
   localparam logic [3:0] KIND_SPARE_15 = 4'd15;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] now_ms;
      logic        booted;
      logic [3:0]  index;
      logic [31:0] ev_time;
      logic [3:0]  kind;
      logic [31:0] argument;
      logic [7:0]  flags;
   } sequencer_request_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] argument;
      logic [3:0]  slot;
      logic [1:0]  outcome;
      logic        last;
   } dispatch_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [2:0]   req_tuser;
   logic [119:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [7:0]   csr_wdata;

   timed_event_table_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // model state: limits, stopwatch, walk position and table
   logic [7:0]  lim_power;
   logic [7:0]  lim_gpio;
   logic [7:0]  lim_cal;
   logic [31:0] clk_start;
   logic [31:0] clk_stop;
   logic        clk_running;
   int          next_slot;
   logic [31:0] tbl_time [DEPTH];
   logic [3:0]  tbl_kind [DEPTH];
   logic [31:0] tbl_argument [DEPTH];
   logic [7:0]  tbl_flags [DEPTH];

   dispatch_type pending_dispatches [$];
   dispatch_type seen_dispatch;
   dispatch_type want_dispatch;

   int mismatches;
   int items_sent;
   int dispatches_seen;
   int outcome_seen [4];
   int csr_writes;
   int full_bursts;
   int burst_left;
   int idle_cycles;

   // 20 time unit clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // model
   // ------------------------------------------------------------------------

   function automatic logic [1:0] judge_outcome(input logic [3:0] kind,
                                                input logic [31:0] argument,
                                                input logic [7:0] flags,
                                                input logic booted);
      logic [7:0] bound;
      if (flags[0] && booted) return OUT_SKIPPED;
      case (kind)
         KIND_LCL: begin
            bound = lim_power;
         end
         KIND_GPIO_SET, KIND_GPIO_CLR: begin
            bound = lim_gpio;
         end
         KIND_CAL: begin
            bound = lim_cal;
         end
         KIND_ACT_A, KIND_ACT_B, KIND_ACT_C: begin
            return OUT_EXECUTED;
         end
         default: begin
            return OUT_NO_ACTION;
         end
      endcase
      return (argument < {24'd0, bound}) ? OUT_EXECUTED : OUT_RANGE;
   endfunction

   // consume every due slot from the walk position, at most one burst
   task automatic walk_due_slots(input logic [31:0] now, input logic booted);
      dispatch_type burst [BURST_MAX];
      logic [31:0]  elapsed;
      int           n;
      n = 0;
      elapsed = now - clk_start;
      while (n < BURST_MAX && next_slot < DEPTH && tbl_kind[next_slot] != KIND_END
             && tbl_time[next_slot] <= elapsed) begin
         burst[n].kind     = tbl_kind[next_slot];
         burst[n].argument = tbl_argument[next_slot];
         burst[n].slot     = 4'(next_slot);
         burst[n].outcome  = judge_outcome(tbl_kind[next_slot], tbl_argument[next_slot],
                                           tbl_flags[next_slot], booted);
         burst[n].last     = 1'b0;
         n++;
         next_slot++;
      end
      if (n == BURST_MAX) full_bursts++;
      for (int i = 0; i < n; i++) begin
         burst[i].last = (i == n - 1);
         pending_dispatches.push_back(burst[i]);
      end
   endtask

   task automatic apply_request(input sequencer_request_type rq);
      case (rq.op)
         REQ_START: begin
            if (!clk_running) begin
               clk_start   = rq.now_ms - (clk_stop - clk_start);
               clk_stop    = '0;
               clk_running = 1'b1;
            end
         end
         REQ_STOP: begin
            if (clk_running) begin
               clk_stop    = rq.now_ms;
               clk_running = 1'b0;
            end
         end
         REQ_RESET: begin
            clk_start = clk_running ? rq.now_ms : '0;
            clk_stop  = '0;
            next_slot = 0;
         end
         REQ_LOAD: begin
            tbl_time[rq.index]     = rq.ev_time;
            tbl_kind[rq.index]     = rq.kind;
            tbl_argument[rq.index] = rq.argument;
            tbl_flags[rq.index]    = rq.flags;
         end
         REQ_TICK: begin
            if (clk_running) walk_due_slots(rq.now_ms, rq.booted);
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // item builders
   // ------------------------------------------------------------------------

   // entry fields are noise unless the request is a load
   function automatic sequencer_request_type make_request(input logic [2:0] op,
                                                          input logic [31:0] now,
                                                          input logic booted);
      sequencer_request_type rq;
      rq.op       = op;
      rq.now_ms   = now;
      rq.booted   = booted;
      rq.index    = 4'($urandom_range(0, 15));
      rq.ev_time  = $urandom();
      rq.kind     = 4'($urandom_range(0, 15));
      rq.argument = $urandom();
      rq.flags    = 8'($urandom_range(0, 255));
      return rq;
   endfunction

   function automatic sequencer_request_type make_load(input logic [3:0] index,
                                                       input logic [31:0] ev_time,
                                                       input logic [3:0] kind,
                                                       input logic [31:0] argument,
                                                       input logic [7:0] flags);
      sequencer_request_type rq;
      rq = make_request(REQ_LOAD, $urandom(), 1'($urandom_range(0, 1)));
      rq.index    = index;
      rq.ev_time  = ev_time;
      rq.kind     = kind;
      rq.argument = argument;
      rq.flags    = flags;
      return rq;
   endfunction

   function automatic sequencer_request_type random_request();
      return make_request(3'($urandom_range(0, 7)), $urandom(), 1'($urandom_range(0, 1)));
   endfunction

   // mostly near the limits, sometimes anywhere in 32 bits
   function automatic logic [31:0] pick_argument();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return 32'($urandom_range(0, 260));
   endfunction

   // ------------------------------------------------------------------------
   // channel drivers
   // ------------------------------------------------------------------------

   // send one item, inserting a random gap at the end of each burst
   task automatic send_request(input sequencer_request_type rq);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = rq.op;
      req_tdata  = {7'd0, rq.flags, rq.argument, rq.kind, rq.ev_time, rq.index,
                    rq.booted, rq.now_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(rq);
      items_sent++;
      @(negedge clock);
   endtask

   // hold input until every dispatch is in, then let the walk settle
   task automatic wait_quiet();
      req_tvalid = 1'b0;
      while (pending_dispatches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_POWER_SWITCHES: lim_power = value;
         CSR_GPIO_PINS:      lim_gpio  = value;
         CSR_CALIBRATIONS:   lim_cal   = value;
         default: begin
         end
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // result side: stall pattern switches among four modes over random spans
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      int beat;
      rsp_tready = 1'b0;
      beat = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 40);
         repeat (span) begin
            @(negedge clock);
            beat++;
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: rsp_tready = ($urandom_range(0, 3) == 0);
               default: rsp_tready = (beat % 3 != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input dispatch_type want,
                                  input dispatch_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%s: expected kind %0d arg 0x%08h slot %0d outcome %0d last %0b",
                  what, want.kind, want.argument, want.slot, want.outcome, want.last);
         $display("   got kind %0d arg 0x%08h slot %0d outcome %0d last %0b",
                  got.kind, got.argument, got.slot, got.outcome, got.last);
      end
   endtask

   // compare each dispatched item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_dispatch.kind     = rsp_tdata[3:0];
         seen_dispatch.argument = rsp_tdata[35:4];
         seen_dispatch.slot     = rsp_tdata[39:36];
         seen_dispatch.outcome  = rsp_tdata[41:40];
         seen_dispatch.last     = rsp_tlast;
         dispatches_seen++;
         outcome_seen[seen_dispatch.outcome]++;
         if (pending_dispatches.size() == 0) begin
            report_mismatch("unexpected dispatch", '0, seen_dispatch);
         end else begin
            want_dispatch = pending_dispatches.pop_front();
            if (seen_dispatch !== want_dispatch)
               report_mismatch("dispatch mismatch", want_dispatch, seen_dispatch);
         end
      end
   end

   // end the run when nothing has moved for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles, %0d dispatches outstanding",
                  idle_cycles, pending_dispatches.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // a stopped tick, spare codes, and a running clock over an empty table
   task automatic test_idle_requests();
      send_request(make_request(REQ_TICK, 32'd500, 1'b1));
      send_request(make_request(REQ_SPARE_5, 32'd510, 1'b0));
      send_request(make_request(REQ_SPARE_6, 32'd520, 1'b1));
      send_request(make_request(REQ_SPARE_7, 32'd530, 1'b0));
      send_request(make_request(REQ_START, 32'd1000, 1'b0));
      send_request(make_request(REQ_TICK, 32'd1005, 1'b0));
   endtask

   // one slot per outcome rule, limits at their reset values
   task automatic test_outcome_rules();
      send_request(make_load(4'd0, 32'd0, KIND_LCL, 32'd7, 8'h00));
      send_request(make_load(4'd1, 32'd0, KIND_LCL, 32'd8, 8'h00));
      send_request(make_load(4'd2, 32'd3, KIND_GPIO_SET, 32'd31, 8'hFF));
      send_request(make_load(4'd3, 32'd3, KIND_GPIO_CLR, 32'd32, 8'hFE));
      send_request(make_load(4'd4, 32'd7, KIND_CAL, 32'hFFFF_FFFF, 8'h00));
      send_request(make_load(4'd5, 32'd7, KIND_ACT_C, $urandom(), 8'h01));
      send_request(make_load(4'd6, 32'd7, KIND_SPARE_15, 32'd0, 8'h00));
      send_request(make_load(4'd7, 32'd7, KIND_NOP, 32'd0, 8'h00));
      send_request(make_load(4'd8, 32'hFFFF_FFFF, KIND_ACT_A, 32'd0, 8'h00));
      // booted: flagged slot is skipped, the others still judged
      send_request(make_request(REQ_TICK, clk_start + 32'd3, 1'b1));
      send_request(make_request(REQ_TICK, clk_start + 32'd10, 1'b0));
   endtask

   // stop/start across zero, latest possible slot, clock resets both ways
   task automatic test_clock_wrap();
      send_request(make_request(REQ_STOP, 32'd5000, 1'b0));
      send_request(make_request(REQ_START, 32'd10, 1'b0));
      send_request(make_request(REQ_TICK, clk_start + 32'hFFFF_FFFF, 1'b0));
      send_request(make_request(REQ_RESET, 32'd777, 1'b0));
      send_request(make_request(REQ_TICK, clk_start, 1'b0));
      send_request(make_request(REQ_STOP, 32'd800, 1'b0));
      send_request(make_request(REQ_RESET, 32'd900, 1'b0));
      send_request(make_request(REQ_START, 32'hFFFF_FFFE, 1'b0));
      send_request(make_request(REQ_TICK, clk_start + 32'd5, 1'b1));
   endtask

   // rewind, load a sorted schedule, start and tick through it
   task automatic play_schedule();
      logic [31:0] due_at;
      logic [31:0] elapsed;
      logic [3:0]  kind;
      int          entries;
      int          ticks;
      if ($urandom_range(0, 1) == 0)
         send_request(make_request(REQ_STOP, $urandom(), 1'b0));
      send_request(make_request(REQ_RESET, $urandom(), 1'b0));
      entries = ($urandom_range(0, 4) == 0) ? DEPTH : $urandom_range(1, 10);
      due_at  = ($urandom_range(0, 7) == 0) ? ($urandom() | 32'h8000_0000)
                                            : 32'($urandom_range(0, 20));
      for (int i = 0; i < entries; i++) begin
         due_at += $urandom_range(0, 30);
         kind = 4'($urandom_range(0, 15));
         if (kind == KIND_END && $urandom_range(0, 3) != 0) kind = KIND_ACT_B;
         send_request(make_load(4'(i), due_at, kind, pick_argument(),
                                8'($urandom_range(0, 255))));
      end
      // terminate the schedule, now and then leave stale slots behind it
      if (entries < DEPTH && $urandom_range(0, 5) != 0)
         send_request(make_load(4'(entries), $urandom(), KIND_END, $urandom(),
                                8'($urandom_range(0, 255))));
      if (!clk_running)
         send_request(make_request(REQ_START, $urandom(), 1'b0));
      elapsed = '0;
      ticks = 0;
      while (ticks < 12 && next_slot < entries) begin
         case ($urandom_range(0, 11))
            0: elapsed = 32'hFFFF_FFFF;
            1: begin
               send_request(make_request(REQ_STOP, clk_start + elapsed, 1'b0));
               send_request(make_request(REQ_START, $urandom(), 1'b0));
            end
            2: send_request(random_request());
            default: elapsed += $urandom_range(0, 45);
         endcase
         send_request(make_request(REQ_TICK, clk_start + elapsed,
                                   $urandom_range(0, 3) == 0));
         ticks++;
      end
      // one more tick once the walk has stopped
      send_request(make_request(REQ_TICK, clk_start + elapsed + $urandom_range(0, 45),
                                $urandom_range(0, 3) == 0));
   endtask

   // random schedules under several limit settings, extremes included
   task automatic test_random_traffic();
      int phase_end;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_quiet();
         case (phase)
            0: begin
               write_register(CSR_POWER_SWITCHES, 8'd0);
               write_register(CSR_GPIO_PINS, 8'd0);
               write_register(CSR_CALIBRATIONS, 8'd0);
            end
            1: begin
               write_register(CSR_POWER_SWITCHES, 8'd255);
               write_register(CSR_GPIO_PINS, 8'd255);
               write_register(CSR_CALIBRATIONS, 8'd255);
            end
            PHASES - 1: begin
               write_register(CSR_POWER_SWITCHES, POWER_SWITCHES_RST);
               write_register(CSR_GPIO_PINS, GPIO_PINS_RST);
               write_register(CSR_CALIBRATIONS, CALIBRATIONS_RST);
            end
            default: begin
               write_register(CSR_POWER_SWITCHES, 8'($urandom_range(0, 255)));
               write_register(CSR_GPIO_PINS, 8'($urandom_range(0, 255)));
               write_register(CSR_CALIBRATIONS, 8'($urandom_range(0, 255)));
            end
         endcase
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) play_schedule();
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = REQ_TICK;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_POWER_SWITCHES;
      csr_wdata  = '0;
      burst_left = 0;
      idle_cycles = 0;
      mismatches = 0;
      items_sent = 0;
      dispatches_seen = 0;
      csr_writes = 0;
      full_bursts = 0;
      for (int i = 0; i < 4; i++) outcome_seen[i] = 0;

      // model matches the block after reset
      lim_power   = POWER_SWITCHES_RST;
      lim_gpio    = GPIO_PINS_RST;
      lim_cal     = CALIBRATIONS_RST;
      clk_start   = '0;
      clk_stop    = '0;
      clk_running = 1'b0;
      next_slot   = 0;
      for (int i = 0; i < DEPTH; i++) begin
         tbl_time[i]     = '0;
         tbl_kind[i]     = KIND_END;
         tbl_argument[i] = '0;
         tbl_flags[i]    = '0;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_requests();
      test_outcome_rules();
      test_clock_wrap();
      test_random_traffic();
      wait_quiet();

      if (pending_dispatches.size() != 0) begin
         $display("%0d dispatches never arrived", pending_dispatches.size());
         mismatches += pending_dispatches.size();
      end
      $display("run: %0d requests, %0d register writes, %0d dispatches (%0d full bursts)",
               items_sent, csr_writes, dispatches_seen, full_bursts);
      $display("outcomes: executed %0d, skipped %0d, out of range %0d, no action %0d",
               outcome_seen[OUT_EXECUTED], outcome_seen[OUT_SKIPPED],
               outcome_seen[OUT_RANGE], outcome_seen[OUT_NO_ACTION]);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/tets_pkg.sv
src/tets_table.sv
src/timed_event_table_sequencer.sv
tb/timed_event_table_sequencer_test.sv
